// ----- src/lst_pkg.sv -----
`default_nettype none
package lst_pkg;
    localparam int HistoryDepth = 64;
    localparam int RingAw = $clog2(HistoryDepth);
    localparam int FillW = RingAw + 1;
    localparam logic [20:0] RttCap = 21'd2000000;
    localparam logic [31:0] CountCap = 32'hFFFF_FFFF;
    localparam logic [5:0] WindowCap = 6'd32;
    localparam logic [5:0] WindowReset = 6'd30;
    localparam logic [3:0] BarTop = 4'd7;
    localparam logic [3:0] BarTimeout = 4'd8;

    typedef struct packed {
        logic [31:0] sent;
        logic [31:0] received;
        logic [20:0] vmin;
        logic [20:0] avg;
        logic [20:0] vmax;
        logic [20:0] jit;
        logic [9:0]  loss;
    } stats_t;

    typedef struct packed {
        logic [3:0] level;
        logic       last;
    } bar_t;

    // unsigned restoring divider request
    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [31:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
    } div_rsp_t;
endpackage
`default_nettype wire

// ----- src/lst_div.sv -----
`default_nettype none
module lst_div (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire lst_pkg::div_req_t req,
    output lst_pkg::div_rsp_t    rsp
);
    import lst_pkg::*;

    logic [63:0] quo_reg;
    logic [31:0] rem_reg;
    logic [31:0] den_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] shifted;
    logic [32:0] diff;

    assign shifted = {rem_reg, quo_reg[63]};
    assign diff    = shifted - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                quo_reg  <= req.num;
                rem_reg  <= '0;
                den_reg  <= req.den;
                cnt_reg  <= 7'd64;
            end else if (busy_reg) begin
                if (!diff[32]) begin
                    rem_reg <= diff[31:0];
                    quo_reg <= {quo_reg[62:0], 1'b1};
                end else begin
                    rem_reg <= shifted[31:0];
                    quo_reg <= {quo_reg[62:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp = {done_reg, quo_reg};

`ifndef SYNTHESIS
    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg) else $error("divider done not a pulse");
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |=> busy_reg) else $error("divider did not start");
    a_cnt_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> cnt_reg != 7'd0) else $error("divider count ran out");
`endif
endmodule
`default_nettype wire

// ----- src/lst_ring.sv -----
`default_nettype none
module lst_ring (
    input  wire logic                      aclk,
    input  wire logic                      we,
    input  wire logic [lst_pkg::RingAw-1:0] waddr,
    input  wire logic [21:0]               wdata,
    input  wire logic [lst_pkg::RingAw-1:0] raddr,
    output logic [21:0]                    rdata
);
    import lst_pkg::*;

    logic [21:0] mem [HistoryDepth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- src/latency_stats_tracker.sv -----
`default_nettype none
// Latency statistics tracker.
// s_axis: one probe outcome per transaction. s_axis_tdata[0] is timed_out,
//   s_axis_tdata[21:1] is rtt_us in microseconds.
// m_axis: a run of transactions per probe, one per recent bar, oldest first;
//   m_axis_tlast marks the newest bar. m_axis_tdata carries the running
//   statistics, m_axis_tuser the bar level (8 = timeout).
// cfg_we/cfg_wdata: bar window, 1..32 (0 acts as 1, above 32 as 32).
// One probe is processed at a time. Per probe: an update state,
//   three sequential divisions (issue, 64 steps, handoff) for
//   average, jitter and loss on one shared restoring divider, one ring read
//   pass for the window maximum, then one emit pass through read, multiply,
//   level and output per bar, output holding until m_axis_tready
//   is high. bars = min(probes so far, window).
// A receiver stall holds the current bar; the ring read waits with it.
// Reset (aresetn low, synchronous) clears counters, totals, min and max (not avg,
//   jitter, loss); the ring contents need no clearing since only written entries are used.
module latency_stats_tracker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [5:0]  cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,  // timed_out, rtt_us[20:0], pad
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [159:0]     m_axis_tdata,  // sent, received, min, avg, max, jitter, loss, pad
    output logic [3:0]       m_axis_tuser,  // bar_level
    output logic             m_axis_tlast
);
    import lst_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_UPD, S_DAVG, S_WAVG, S_DJIT, S_WJIT, S_DLOSS, S_WLOSS,
        S_SCAN, S_RD, S_MUL, S_LVL, S_OUT
    } state_t;

    state_t state_reg;
    logic [5:0]  win_reg;
    logic [RingAw-1:0] wpos_reg;
    logic [FillW-1:0]  fill_reg;
    logic [20:0] min_reg, max_reg, prev_reg;
    logic        prev_v_reg;
    logic [63:0] rtt_tot_reg, jit_tot_reg;
    logic [31:0] sent_reg, recv_reg;
    logic        in_to_reg;
    logic [20:0] in_rtt_reg;
    logic [20:0] avg_reg, jit_reg;
    logic [9:0]  loss_reg;
    logic [5:0]  shown_reg, idx_reg;
    logic [20:0] wmax_reg;
    logic        scan_v_reg;
    logic [23:0] prod_reg;
    logic        e_to_reg;
    logic [3:0]  lvl_reg;
    logic        last_reg;
    logic        out_v_reg;

    logic            ring_we;
    logic [RingAw-1:0] ring_raddr;
    logic [21:0]     ring_rdata;
    div_req_t        dreq;
    div_rsp_t        drsp;

    lst_ring u_ring (
        .aclk (aclk), .we (ring_we), .waddr (wpos_reg),
        .wdata ({in_to_reg, in_to_reg ? 21'd0 : in_rtt_reg}),
        .raddr (ring_raddr), .rdata (ring_rdata)
    );

    lst_div u_div (.aclk (aclk), .aresetn (aresetn), .req (dreq), .rsp (drsp));

    logic [5:0] win_eff;
    logic [FillW-1:0] fill_p1;
    logic [20:0] rtt_sat;
    logic [20:0] adiff;
    logic [RingAw-1:0] base_addr;
    logic [23:0] wmax7;
    logic [23:0] wmax_ext;

    always_comb begin
        win_eff = win_reg;
        if (win_eff == 6'd0) win_eff = 6'd1;
        if (win_eff > WindowCap) win_eff = WindowCap;
        fill_p1 = fill_reg;
        rtt_sat = s_axis_tdata[21:1] > RttCap ? RttCap : s_axis_tdata[21:1];
        adiff = in_rtt_reg > prev_reg ? in_rtt_reg - prev_reg : prev_reg - in_rtt_reg;
        base_addr = wpos_reg - RingAw'(shown_reg);
        ring_raddr = base_addr + RingAw'(idx_reg);
        wmax_ext = {3'd0, wmax_reg};
        wmax7 = {wmax_reg, 3'd0} - wmax_ext;
        ring_we = (state_reg == S_UPD);
        dreq = '0;
        case (state_reg)
            S_DAVG: begin
                dreq.start = 1'b1; dreq.num = rtt_tot_reg; dreq.den = recv_reg;
            end
            S_DJIT: begin
                dreq.start = 1'b1; dreq.num = jit_tot_reg; dreq.den = recv_reg - 32'd1;
            end
            S_DLOSS: begin
                dreq.start = 1'b1;
                dreq.num = 64'(sent_reg - recv_reg) * 64'd1000;
                dreq.den = sent_reg;
            end
            default: ;
        endcase
    end

    logic [63:0] q_sat;
    assign q_sat = drsp.quo > 64'(RttCap) ? 64'(RttCap) : drsp.quo;

    // level = floor(s*7/wmax) via compare against k*wmax, k = 1..7
    logic [3:0] lvl_calc;
    always_comb begin
        lvl_calc = 4'd0;
        for (int k = 1; k <= 7; k++) begin
            if (prod_reg >= 24'(k) * wmax_ext) lvl_calc = 4'(k);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            win_reg <= WindowReset;
            wpos_reg <= '0;
            fill_reg <= '0;
            min_reg <= '1;
            max_reg <= '0;
            prev_reg <= '0;
            prev_v_reg <= 1'b0;
            rtt_tot_reg <= '0;
            jit_tot_reg <= '0;
            sent_reg <= '0;
            recv_reg <= '0;
            out_v_reg <= 1'b0;
        end else begin
            if (cfg_we) win_reg <= cfg_wdata;
            unique case (state_reg)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        in_to_reg <= s_axis_tdata[0];
                        in_rtt_reg <= rtt_sat;
                        state_reg <= S_UPD;
                    end
                end
                S_UPD: begin
                    wpos_reg <= wpos_reg + RingAw'(1);
                    if (fill_reg != FillW'(HistoryDepth)) fill_reg <= fill_p1 + FillW'(1);
                    if (sent_reg != CountCap) sent_reg <= sent_reg + 32'd1;
                    if (!in_to_reg) begin
                        if (recv_reg != CountCap) begin
                            recv_reg <= recv_reg + 32'd1;
                            rtt_tot_reg <= rtt_tot_reg + 64'(in_rtt_reg);
                            if (prev_v_reg) jit_tot_reg <= jit_tot_reg + 64'(adiff);
                        end
                        if (in_rtt_reg < min_reg) min_reg <= in_rtt_reg;
                        if (in_rtt_reg > max_reg) max_reg <= in_rtt_reg;
                        prev_reg <= in_rtt_reg;
                        prev_v_reg <= 1'b1;
                    end
                    shown_reg <= (fill_reg + FillW'(1)) < FillW'(win_eff)
                        ? 6'(fill_reg + FillW'(1)) : win_eff;
                    state_reg <= S_DAVG;
                end
                S_DAVG: state_reg <= S_WAVG;
                S_WAVG: if (drsp.done) begin
                    avg_reg <= recv_reg != 32'd0 ? q_sat[20:0] : 21'd0;
                    state_reg <= S_DJIT;
                end
                S_DJIT: state_reg <= S_WJIT;
                S_WJIT: if (drsp.done) begin
                    jit_reg <= recv_reg > 32'd1 ? q_sat[20:0] : 21'd0;
                    state_reg <= S_DLOSS;
                end
                S_DLOSS: state_reg <= S_WLOSS;
                S_WLOSS: if (drsp.done) begin
                    loss_reg <= drsp.quo[9:0];
                    idx_reg <= '0;
                    wmax_reg <= '0;
                    scan_v_reg <= 1'b0;
                    state_reg <= S_SCAN;
                end
                S_SCAN: begin
                    if (scan_v_reg && !ring_rdata[21] && ring_rdata[20:0] > wmax_reg)
                        wmax_reg <= ring_rdata[20:0];
                    if (idx_reg == shown_reg) begin
                        idx_reg <= '0;
                        state_reg <= S_RD;
                    end else begin
                        idx_reg <= idx_reg + 6'd1;
                        scan_v_reg <= 1'b1;
                    end
                end
                S_RD: begin
                    if (wmax_reg == 21'd0) wmax_reg <= 21'd1;
                    state_reg <= S_MUL;
                end
                S_MUL: begin
                    e_to_reg <= ring_rdata[21];
                    prod_reg <= {ring_rdata[20:0], 3'd0} - {3'd0, ring_rdata[20:0]};
                    state_reg <= S_LVL;
                end
                S_LVL: begin
                    lvl_reg <= e_to_reg ? BarTimeout
                        : (prod_reg >= wmax7 ? BarTop : lvl_calc);
                    last_reg <= (idx_reg + 6'd1) == shown_reg;
                    out_v_reg <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        out_v_reg <= 1'b0;
                        if (last_reg) begin
                            state_reg <= S_IDLE;
                        end else begin
                            idx_reg <= idx_reg + 6'd1;
                            state_reg <= S_RD;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tuser  = lvl_reg;
    assign m_axis_tlast  = last_reg;
    assign m_axis_tdata  = {2'd0, loss_reg, jit_reg, max_reg, avg_reg,
                            recv_reg != 32'd0 ? min_reg : 21'd0, recv_reg, sent_reg};

`ifndef SYNTHESIS
    a_ready_out: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_axis_tready && m_axis_tvalid)) else $error("accepting while emitting");
    a_recv_le_sent: assert property (@(posedge aclk) disable iff (!aresetn)
        recv_reg <= sent_reg) else $error("received exceeds sent");
    a_shown_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (shown_reg != 6'd0 && idx_reg < shown_reg))
        else $error("bar index out of window");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tuser))
        else $error("bar changed under stall");
`endif
endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
`default_nettype none

module tb;
    import lst_pkg::*;

    class bar_scoreboard;
        logic [21:0] ring [HistoryDepth];
        int unsigned wr_pos, fill;
        logic [20:0] min_rtt, max_rtt, last_good_rtt;
        logic        prev_ok;
        logic [63:0] rtt_sum, diff_sum;
        logic [31:0] sent, rcvd;
        logic [5:0]  window;
        stats_t      stats_q [$];
        bar_t        bar_q [$];
        int          errors;
        int          bars_seen;

        function void clear();
            wr_pos = 0; fill = 0; min_rtt = '1; max_rtt = 0; last_good_rtt = 0; prev_ok = 0;
            rtt_sum = 0; diff_sum = 0; sent = 0; rcvd = 0; window = WindowReset;
            errors = 0; bars_seen = 0;
        endfunction

        function void note_probe(logic tmo, logic [20:0] rtt_in);
            logic [20:0] rtt, wmax;
            logic [63:0] q, lvl;
            logic [21:0] e;
            int unsigned win, shown, idx;
            stats_t st;
            bar_t b;
            bit room;
            rtt = (rtt_in > RttCap) ? RttCap : rtt_in;
            if (tmo) rtt = 0;
            if (sent != CountCap) sent++;
            ring[wr_pos] = tmo ? {1'b1, 21'd0} : {1'b0, rtt};
            wr_pos = (wr_pos + 1) % HistoryDepth;
            if (fill < HistoryDepth) fill++;
            if (!tmo) begin
                room = rcvd != CountCap;
                if (room) rcvd++;
                if (rtt < min_rtt) min_rtt = rtt;
                if (rtt > max_rtt) max_rtt = rtt;
                if (room) begin
                    rtt_sum += rtt;
                    if (prev_ok)
                        diff_sum += (rtt > last_good_rtt) ? rtt - last_good_rtt
                                                          : last_good_rtt - rtt;
                end
                last_good_rtt = rtt;
                prev_ok = 1;
            end
            st.sent = sent;
            st.received = rcvd;
            st.vmin = rcvd > 0 ? min_rtt : 0;
            q = rcvd > 0 ? rtt_sum / rcvd : 0;
            st.avg = q > RttCap ? RttCap : q[20:0];
            q = rcvd > 1 ? diff_sum / (rcvd - 1) : 0;
            st.jit = q > RttCap ? RttCap : q[20:0];
            st.vmax = max_rtt;
            q = (64'(sent - rcvd) * 1000) / sent;
            st.loss = q[9:0];
            win = window == 0 ? 1 : (window > WindowCap ? WindowCap : window);
            shown = fill < win ? fill : win;
            wmax = 0;
            for (int i = 0; i < shown; i++) begin
                e = ring[(wr_pos + HistoryDepth - shown + i) % HistoryDepth];
                if (!e[21] && e[20:0] > wmax) wmax = e[20:0];
            end
            if (wmax == 0) wmax = 1;
            for (int i = 0; i < shown; i++) begin
                idx = (wr_pos + HistoryDepth - shown + i) % HistoryDepth;
                e = ring[idx];
                if (e[21]) b.level = BarTimeout;
                else begin
                    lvl = (64'(e[20:0]) * BarTop) / wmax;
                    b.level = lvl > BarTop ? BarTop : lvl[3:0];
                end
                b.last = (i + 1 == shown);
                stats_q.push_back(st);
                bar_q.push_back(b);
            end
        endfunction

        function void check_bar(logic [159:0] data, logic [3:0] lvl, logic lst);
            stats_t exp_st, got;
            bar_t exp_b;
            bars_seen++;
            if (stats_q.size() == 0) begin
                $display("%0t unexpected bar: data %h level %0d", $realtime, data, lvl);
                errors++;
                return;
            end
            exp_st = stats_q.pop_front();
            exp_b = bar_q.pop_front();
            got.sent = data[31:0];
            got.received = data[63:32];
            got.vmin = data[84:64];
            got.avg = data[105:85];
            got.vmax = data[126:106];
            got.jit = data[147:127];
            got.loss = data[157:148];
            if (got.sent !== exp_st.sent) report("sent", exp_st.sent, got.sent);
            if (got.received !== exp_st.received)
                report("received", exp_st.received, got.received);
            if (got.vmin !== exp_st.vmin) report("min", exp_st.vmin, got.vmin);
            if (got.avg !== exp_st.avg) report("avg", exp_st.avg, got.avg);
            if (got.vmax !== exp_st.vmax) report("max", exp_st.vmax, got.vmax);
            if (got.jit !== exp_st.jit) report("jitter", exp_st.jit, got.jit);
            if (got.loss !== exp_st.loss) report("loss", exp_st.loss, got.loss);
            if (lvl !== exp_b.level) report("level", exp_b.level, lvl);
            if (lst !== exp_b.last) report("last", exp_b.last, lst);
        endfunction

        function void report(string what, logic [63:0] e, logic [63:0] a);
            $display("%0t %s: expected %0d actual %0d", $realtime, what, e, a);
            errors++;
        endfunction
    endclass

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         cfg_we = 0;
    logic [5:0]   cfg_wdata = 0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [23:0]  s_axis_tdata = 0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [159:0] m_axis_tdata;
    logic [3:0]   m_axis_tuser;
    logic         m_axis_tlast;

    bar_scoreboard sb;
    bit quiet;
    int probes;

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    latency_stats_tracker u_dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast)
    );

    // receiver with bursty stalls
    initial begin
        int hold;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_bar(m_axis_tdata, m_axis_tuser, m_axis_tlast);
            if (hold > 0) hold--;
            else if (!quiet && $urandom_range(0, 5) == 0) hold = $urandom_range(1, 16);
            m_axis_tready <= (hold == 0);
        end
    end

    task automatic send_probe(logic tmo, logic [20:0] rtt);
        if (!quiet && $urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        s_axis_tvalid <= 1;
        s_axis_tdata <= {2'b00, rtt, tmo};
        do @(posedge aclk); while (!s_axis_tready);
        sb.note_probe(tmo, rtt);
        probes++;
        s_axis_tvalid <= 0;
        @(posedge aclk);
    endtask

    task automatic drain();
        while (sb.stats_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic set_window(logic [5:0] w);
        drain();
        cfg_we <= 1;
        cfg_wdata <= w;
        @(posedge aclk);
        cfg_we <= 0;
        sb.window = w;
    endtask

    task automatic random_probe();
        int k;
        logic [20:0] r;
        k = $urandom_range(0, 9);
        if (k == 0) r = 21'($urandom_range(RttCap + 1, 21'h1FFFFF));
        else if (k < 3) r = 21'($urandom);
        else if (k < 5) r = 21'($urandom_range(0, 20));
        else r = 21'($urandom_range(1000, 60000));
        send_probe($urandom_range(0, 5) == 0, r);
    endtask

    initial begin
        logic [5:0] wins [6] = '{6'd0, 6'd1, 6'd63, 6'd32, 6'd7, 6'd33};
        sb = new();
        sb.clear();
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        send_probe(1, 21'd5);
        send_probe(0, 21'd0);
        send_probe(0, 21'd0);
        send_probe(0, RttCap);
        send_probe(0, 21'h1FFFFF);
        send_probe(0, 21'd1);
        send_probe(1, 21'h1FFFFF);
        send_probe(0, 21'h0AAAAA);
        send_probe(0, 21'h155555);
        send_probe(1, 21'd0);
        send_probe(0, 21'd3);
        for (int p = 0; p < 6; p++) begin
            set_window(wins[p]);
            for (int i = 0; i < 12; i++) random_probe();
            if (p == 2) for (int i = 0; i < 60; i++) random_probe();
        end
        set_window(6'($urandom_range(1, 32)));
        for (int i = 0; i < 250; i++) begin
            if (i % 50 == 49) set_window(6'($urandom_range(0, 63)));
            random_probe();
        end
        quiet = 1;
        for (int i = 0; i < 67; i++) random_probe();
        drain();
        $display("Covered %0d probes and %0d bars across windows 0..63, timeouts, saturation",
                 probes, sb.bars_seen);
        if (sb.errors == 0 && sb.stats_q.size() == 0)
            $display("latency_stats_tracker: match");
        else
            $display("latency_stats_tracker: mismatch");
        $finish;
    end

    initial begin
        #20ms;
        $display("latency_stats_tracker: mismatch");
        $finish;
    end
endmodule

`default_nettype wire
